// ----- src/ctd_pkg.sv -----
// Shared types and constants for the chunked transfer decoder.
package ctd_pkg;

    localparam int LEN_BITS_DEF = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] data;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       eob;
    } t_item;

endpackage

// ----- src/ctd_front.sv -----
// Front end: accepts body bytes and classifies them into queue items.
module ctd_front (
    input  logic           i_valid,
    input  logic [7:0]     i_in_byte,
    input  logic           i_end_of_body,
    output logic           o_stall,
    input  logic           i_queue_full,
    output logic           o_push,
    output ctd_pkg::t_item o_item
);

    always_comb begin
        o_item         = '0;
        o_item.data    = i_in_byte;
        o_item.is_cr   = (i_in_byte == ctd_pkg::CHAR_CR);
        o_item.is_lf   = (i_in_byte == ctd_pkg::CHAR_LF);
        o_item.eob     = i_end_of_body;
        o_item.hex_ok  = 1'b0;
        o_item.hex_val = 4'd0;
        if (i_in_byte inside {[8'h30:8'h39]}) begin
            o_item.hex_ok  = 1'b1;
            o_item.hex_val = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte inside {[8'h61:8'h66]}) begin
            o_item.hex_ok  = 1'b1;
            o_item.hex_val = 4'(i_in_byte - 8'h57);
        end else if (i_in_byte inside {[8'h41:8'h46]}) begin
            o_item.hex_ok  = 1'b1;
            o_item.hex_val = 4'(i_in_byte - 8'h37);
        end
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid & ~i_queue_full;

endmodule

// ----- src/ctd_queue.sv -----
// Short queue of classified beats between front and back.
module ctd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ctd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output ctd_pkg::t_item o_item
);

    localparam int AW = ctd_pkg::QUEUE_AW;

    ctd_pkg::t_item r_slot [ctd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [AW:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_full      = (r_count == (AW+1)'(ctd_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_slot[r_rd_ptr];

endmodule

// ----- src/ctd_back.sv -----
// Back end: chunk parser state machine and registered result stage.
module ctd_back #(
    parameter int LEN_BITS = ctd_pkg::LEN_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_not_empty,
    input  ctd_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_payload_valid,
    output logic [7:0]     o_payload_byte,
    output logic           o_chunk_last,
    output logic [1:0]     o_decode_status
);

    localparam logic [2:0] PH_SIZE_FIRST = 3'd0;
    localparam logic [2:0] PH_SIZE_REST  = 3'd1;
    localparam logic [2:0] PH_DATA       = 3'd2;
    localparam logic [2:0] PH_DATA_CR    = 3'd3;
    localparam logic [2:0] PH_DATA_LF    = 3'd4;
    localparam logic [2:0] PH_STOPPED    = 3'd5;

    logic [2:0]          r_phase, n_phase;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic                r_closed, n_closed;
    logic                r_cr_seen, n_cr_seen;
    logic [1:0]          r_final, n_final;

    logic                r_valid;
    logic                r_pv, n_pv;
    logic [7:0]          r_byte, n_byte;
    logic                r_last, n_last;
    logic [1:0]          r_status, n_status;

    assign o_pop = i_not_empty & (~r_valid | ~i_stall);

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_closed  = r_closed;
        n_cr_seen = r_cr_seen;
        n_final   = r_final;
        n_pv      = 1'b0;
        n_byte    = 8'd0;
        n_last    = 1'b0;
        case (r_phase)
            PH_SIZE_FIRST: begin
                if (!i_item.hex_ok) begin
                    n_phase = PH_STOPPED;
                    n_final = ctd_pkg::ST_BAD;
                end else begin
                    n_len     = LEN_BITS'(i_item.hex_val);
                    n_closed  = 1'b0;
                    n_cr_seen = 1'b0;
                    n_phase   = PH_SIZE_REST;
                end
            end
            PH_SIZE_REST: begin
                if (r_cr_seen && i_item.is_lf) begin
                    n_cr_seen = 1'b0;
                    n_closed  = 1'b0;
                    if (r_len == '0) begin
                        n_phase = PH_STOPPED;
                        n_final = ctd_pkg::ST_COMPLETE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (i_item.is_cr) begin
                    n_cr_seen = 1'b1;
                    n_closed  = 1'b1;
                end else begin
                    n_cr_seen = 1'b0;
                    if (!r_closed && i_item.hex_ok) begin
                        if (r_len[LEN_BITS-1 -: 4] != 4'd0) begin
                            n_phase = PH_STOPPED;
                            n_final = ctd_pkg::ST_BAD;
                        end else begin
                            n_len = {r_len[LEN_BITS-5:0], i_item.hex_val};
                        end
                    end else begin
                        n_closed = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                n_pv   = 1'b1;
                n_byte = i_item.data;
                n_len  = r_len - 1'b1;
                if (r_len == LEN_BITS'(1)) begin
                    n_last  = 1'b1;
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (i_item.is_cr) begin
                    n_phase = PH_DATA_LF;
                end else begin
                    n_phase = PH_STOPPED;
                    n_final = ctd_pkg::ST_BAD;
                end
            end
            PH_DATA_LF: begin
                if (i_item.is_lf) begin
                    n_phase = PH_SIZE_FIRST;
                    n_len   = '0;
                end else begin
                    n_phase = PH_STOPPED;
                    n_final = ctd_pkg::ST_BAD;
                end
            end
            default: begin
            end
        endcase

        n_status = (n_phase == PH_STOPPED) ? n_final : ctd_pkg::ST_RUNNING;
        if (i_item.eob) begin
            if (n_status == ctd_pkg::ST_RUNNING) begin
                n_status = ctd_pkg::ST_TRUNCATED;
            end
            n_phase   = PH_SIZE_FIRST;
            n_len     = '0;
            n_closed  = 1'b0;
            n_cr_seen = 1'b0;
            n_final   = ctd_pkg::ST_RUNNING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIZE_FIRST;
            r_len     <= '0;
            r_closed  <= 1'b0;
            r_cr_seen <= 1'b0;
            r_final   <= ctd_pkg::ST_RUNNING;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase   <= n_phase;
                r_len     <= n_len;
                r_closed  <= n_closed;
                r_cr_seen <= n_cr_seen;
                r_final   <= n_final;
                r_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pv     <= n_pv;
            r_byte   <= n_byte;
            r_last   <= n_last;
            r_status <= n_status;
        end
    end

    assign o_valid         = r_valid;
    assign o_payload_valid = r_pv;
    assign o_payload_byte  = r_byte;
    assign o_chunk_last    = r_last;
    assign o_decode_status = r_status;

`ifndef SYNTHESIS
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_pv) |->
            (r_status == ctd_pkg::ST_RUNNING || r_status == ctd_pkg::ST_TRUNCATED))
        else $error("payload beat carries a stopped status");

    a_last_needs_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> r_pv)
        else $error("chunk_last without payload");

    a_data_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != '0))
        else $error("data phase with zero remaining length");

    a_eob_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.eob) |=> (r_phase == PH_SIZE_FIRST && r_final == ctd_pkg::ST_RUNNING))
        else $error("state not restarted after end of body");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_status) && $stable(r_byte)))
        else $error("stalled result changed");
`endif

endmodule

// ----- src/chunked_transfer_decoder_core.sv -----
// Top level of the chunked transfer decoder.
// Input channel: i_valid / o_stall carry one body byte (i_in_byte) per beat, with
// i_end_of_body marking the final byte of a body. A beat is taken when i_valid is
// high and o_stall is low. Output channel: o_valid / i_stall carry exactly one
// result beat per input beat, in order: o_payload_valid, o_payload_byte,
// o_chunk_last and o_decode_status (0 running, 1 complete, 2 malformed or
// overflow, 3 truncated by end of body).
// A result beat passes through the queue and then the registered result stage.
// Throughput is one byte per clock while i_stall is low; the chunk parser
// updates its state once per byte and the result register reloads in the
// cycle it is taken.
// A four-entry queue sits between the byte classifier and the parser, so
// o_stall only rises once the queue has filled behind a stalled receiver.
// While i_stall is high a valid result beat holds and the parser stops popping.
// Synchronous active-low reset empties the queue and the result stage and
// returns the parser to the start of a chunk-size line. The byte marked
// end of body also returns all parser state to that point.
module chunked_transfer_decoder_core #(
    parameter int LEN_BITS = ctd_pkg::LEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_body,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_chunk_last,
    output logic [1:0] o_decode_status
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_not_empty;
    ctd_pkg::t_item w_in_item;
    ctd_pkg::t_item w_out_item;

    ctd_front u_front (
        .i_valid       (i_valid),
        .i_in_byte     (i_in_byte),
        .i_end_of_body (i_end_of_body),
        .o_stall       (o_stall),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_item        (w_in_item)
    );

    ctd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_in_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_item      (w_out_item)
    );

    ctd_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_not_empty     (w_not_empty),
        .i_item          (w_out_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_chunk_last    (o_chunk_last),
        .o_decode_status (o_decode_status)
    );

endmodule
